// ===== src/lzwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwd_pkg
// shared types and constants of the lzw stream decompressor
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam int unsigned StackDepth = 65536;
	localparam int unsigned StackAw    = 16;
	localparam int unsigned GroupMax   = 16;

	localparam logic [7:0]  MAGIC_0    = 8'h1F;
	localparam logic [7:0]  MAGIC_1    = 8'h9D;
	localparam logic [16:0] CODE_CLEAR = 17'd256;
	localparam logic [16:0] CODE_FIRST = 17'd257;
	localparam logic [4:0]  START_BITS = 5'd9;
	localparam logic [4:0]  TOP_BITS   = 5'd16;
	localparam logic [16:0] START_LIM  = 17'd511;
	localparam logic [1:0]  HDR_DONE   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_BYTE      = 3'd0;
	localparam logic [2:0] ST_ACCEPTED  = 3'd1;
	localparam logic [2:0] ST_BUSY      = 3'd2;
	localparam logic [2:0] ST_NEED      = 3'd3;
	localparam logic [2:0] ST_END       = 3'd4;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd5;
	localparam logic [2:0] ST_TOO_WIDE  = 3'd6;
	localparam logic [2:0] ST_PREMATURE = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ADD,
		S_TEST,
		S_DECIDE,
		S_WALK,
		S_WALK_DATA,
		S_CHAR_DATA,
		S_FINISH,
		S_LAST,
		S_POP_ADDR,
		S_POP_DATA,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_CAPTURE,
		C_RES_PULL,
		C_RES_PUSH,
		C_HEADER,
		C_GROUP_START,
		C_ADD_BYTE,
		C_TAKE,
		C_CODE_START,
		C_WALK_ADDR,
		C_WALK_DATA,
		C_CHAR_DATA,
		C_FINISH,
		C_LAST,
		C_POP_ADDR,
		C_POP_DATA
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic err;
		logic ended;
		logic sp_nz;
		logic hdr_done;
		logic fill_zero;
		logic code_ready;
		logic code_simple;
		logic cur_big;
		logic sp_room;
		logic out_free;
	} dp_status_t;

endpackage

// ===== src/lzwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzwd_ctrl
// sequencer: steps the datapath through header, code and pull handling
// ----------------------------------------------------------------------------
module lzwd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lzwd_pkg::dp_status_t  st,
	output lzwd_pkg::cmd_t        cmd,
	output logic                  emit
);

	lzwd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = lzwd_pkg::C_NONE;
		in_ready = 1'b0;
		emit     = 1'b0;
		case (state_q)
			lzwd_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = lzwd_pkg::C_CAPTURE;
					state_d = lzwd_pkg::S_DISPATCH;
				end
			end
			lzwd_pkg::S_DISPATCH: begin
				if (st.kind) begin
					if (st.sp_nz) begin
						state_d = lzwd_pkg::S_POP_ADDR;
					end else begin
						cmd     = lzwd_pkg::C_RES_PULL;
						state_d = lzwd_pkg::S_EMIT;
					end
				end else if (st.err || st.ended || st.sp_nz) begin
					cmd     = lzwd_pkg::C_RES_PUSH;
					state_d = lzwd_pkg::S_EMIT;
				end else if (!st.hdr_done) begin
					cmd     = lzwd_pkg::C_HEADER;
					state_d = lzwd_pkg::S_LAST;
				end else if (st.fill_zero) begin
					cmd     = lzwd_pkg::C_GROUP_START;
					state_d = lzwd_pkg::S_ADD;
				end else begin
					cmd     = lzwd_pkg::C_ADD_BYTE;
					state_d = lzwd_pkg::S_TEST;
				end
			end
			lzwd_pkg::S_ADD: begin
				cmd     = lzwd_pkg::C_ADD_BYTE;
				state_d = lzwd_pkg::S_TEST;
			end
			lzwd_pkg::S_TEST: begin
				if (st.code_ready) begin
					cmd     = lzwd_pkg::C_TAKE;
					state_d = lzwd_pkg::S_DECIDE;
				end else begin
					state_d = lzwd_pkg::S_LAST;
				end
			end
			lzwd_pkg::S_DECIDE: begin
				cmd     = lzwd_pkg::C_CODE_START;
				state_d = st.code_simple ? lzwd_pkg::S_LAST : lzwd_pkg::S_WALK;
			end
			lzwd_pkg::S_WALK: begin
				cmd = lzwd_pkg::C_WALK_ADDR;
				if (st.cur_big && st.sp_room) begin
					state_d = lzwd_pkg::S_WALK_DATA;
				end else if (st.cur_big) begin
					state_d = lzwd_pkg::S_CHAR_DATA;
				end else begin
					state_d = lzwd_pkg::S_FINISH;
				end
			end
			lzwd_pkg::S_WALK_DATA: begin
				cmd     = lzwd_pkg::C_WALK_DATA;
				state_d = lzwd_pkg::S_WALK;
			end
			lzwd_pkg::S_CHAR_DATA: begin
				cmd     = lzwd_pkg::C_CHAR_DATA;
				state_d = lzwd_pkg::S_FINISH;
			end
			lzwd_pkg::S_FINISH: begin
				cmd     = lzwd_pkg::C_FINISH;
				state_d = lzwd_pkg::S_LAST;
			end
			lzwd_pkg::S_LAST: begin
				cmd     = lzwd_pkg::C_LAST;
				state_d = lzwd_pkg::S_EMIT;
			end
			lzwd_pkg::S_POP_ADDR: begin
				cmd     = lzwd_pkg::C_POP_ADDR;
				state_d = lzwd_pkg::S_POP_DATA;
			end
			lzwd_pkg::S_POP_DATA: begin
				cmd     = lzwd_pkg::C_POP_DATA;
				state_d = lzwd_pkg::S_EMIT;
			end
			lzwd_pkg::S_EMIT: begin
				if (st.out_free) begin
					emit    = 1'b1;
					state_d = lzwd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lzwd_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/lzwd_dp.sv =====
// ----------------------------------------------------------------------------
// lzwd_dp
// datapath: bit unpacking, dictionary, reverse stack and result registers
// ----------------------------------------------------------------------------
module lzwd_dp #(
	parameter int unsigned MAX_CODE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  kind,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	input  lzwd_pkg::cmd_t        cmd,
	input  logic                  emit,
	output lzwd_pkg::dp_status_t  st,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic [2:0]            status,
	output logic                  out_last
);

	localparam int unsigned Aw    = MAX_CODE_BITS;
	localparam int unsigned Depth = 1 << Aw;

	// dictionary and stack memories
	logic [15:0] prefix_mem [Depth];
	logic [7:0]  suffix_mem [Depth];
	logic [7:0]  stack_mem  [lzwd_pkg::StackDepth];

	logic [15:0] pre_rd_q;
	logic [7:0]  suf_rd_q, stk_rd_q;

	// captured item
	logic        kind_q, last_q;
	logic [7:0]  byte_q;

	// decoder state
	logic [4:0]  fill_q, cnt_q, cw_q, smb_q;
	logic [23:0] acc_q;
	logic [16:0] wlc_q, nfc_q, sp_q;
	logic [15:0] prev_code_q, code_q, cur_q, incoming_q;
	logic [7:0]  prev_char_q;
	logic [1:0]  hp_q;
	logic [2:0]  err_q;
	logic        bm_q, cp_q, ended_q, fp_q, ac_q;

	// result and output registers
	logic [7:0]  res_byte_q;
	logic [2:0]  res_status_q;
	logic        res_last_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [2:0]  out_status_q;
	logic        out_last_q;

	logic        push_en, tab_we, tab_room, blocked;
	logic [7:0]  push_data;
	logic [16:0] sp_m1, mask17, cw_lim, one_smb;
	logic [4:0]  cw_inc;
	logic [2:0]  err_new;

	assign sp_m1    = sp_q - 17'd1;
	assign mask17   = (17'd1 << cw_q) - 17'd1;
	assign one_smb  = 17'd1 << smb_q;
	assign cw_inc   = (cw_q < lzwd_pkg::TOP_BITS) ? cw_q + 5'd1 : cw_q;
	assign cw_lim   = (cw_inc == smb_q) ? one_smb : (17'd1 << cw_inc) - 17'd1;
	assign blocked  = (nfc_q > wlc_q) || cp_q;
	assign tab_room = (nfc_q < one_smb) && !nfc_q[16];
	assign tab_we   = (cmd == lzwd_pkg::C_FINISH) && tab_room;

	// premature end when the stream stops before a usable code
	always_comb begin
		err_new = err_q;
		if (err_q == lzwd_pkg::ST_BYTE && last_q &&
				(hp_q != lzwd_pkg::HDR_DONE || fp_q || ac_q)) begin
			err_new = lzwd_pkg::ST_PREMATURE;
		end
	end

	always_comb begin
		push_en   = 1'b0;
		push_data = prev_char_q;
		case (cmd)
			lzwd_pkg::C_CODE_START: begin
				if (fp_q) begin
					push_en   = 1'b1;
					push_data = code_q[7:0];
				end else if (!(code_q == lzwd_pkg::CODE_CLEAR[15:0] && bm_q && !ac_q)) begin
					push_en = ({1'b0, code_q} >= nfc_q);
				end
			end
			lzwd_pkg::C_WALK_DATA: begin
				push_en   = 1'b1;
				push_data = suf_rd_q;
			end
			lzwd_pkg::C_FINISH: begin
				push_en = 1'b1;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tab_we) begin
			prefix_mem[nfc_q[Aw-1:0]] <= prev_code_q;
			suffix_mem[nfc_q[Aw-1:0]] <= prev_char_q;
		end
		pre_rd_q <= prefix_mem[cur_q[Aw-1:0]];
		suf_rd_q <= suffix_mem[cur_q[Aw-1:0]];
	end

	always_ff @(posedge clk) begin
		if (push_en && !sp_q[16]) begin
			stack_mem[sp_q[lzwd_pkg::StackAw-1:0]] <= push_data;
		end
		stk_rd_q <= stack_mem[sp_m1[lzwd_pkg::StackAw-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q       <= 1'b0;
			last_q       <= 1'b0;
			byte_q       <= '0;
			fill_q       <= '0;
			cnt_q        <= '0;
			acc_q        <= '0;
			cw_q         <= lzwd_pkg::START_BITS;
			wlc_q        <= lzwd_pkg::START_LIM;
			smb_q        <= '0;
			bm_q         <= 1'b0;
			nfc_q        <= lzwd_pkg::CODE_FIRST;
			prev_code_q  <= '0;
			prev_char_q  <= '0;
			code_q       <= '0;
			cur_q        <= '0;
			incoming_q   <= '0;
			sp_q         <= '0;
			hp_q         <= '0;
			cp_q         <= 1'b0;
			ended_q      <= 1'b0;
			err_q        <= lzwd_pkg::ST_BYTE;
			fp_q         <= 1'b0;
			ac_q         <= 1'b0;
			res_byte_q   <= '0;
			res_status_q <= lzwd_pkg::ST_BYTE;
			res_last_q   <= 1'b0;
		end else begin
			if (push_en && !sp_q[16]) begin
				sp_q <= sp_q + 17'd1;
			end
			case (cmd)
				lzwd_pkg::C_CAPTURE: begin
					kind_q <= kind;
					byte_q <= in_byte;
					last_q <= in_last;
				end
				lzwd_pkg::C_RES_PULL, lzwd_pkg::C_RES_PUSH: begin
					res_byte_q <= '0;
					res_last_q <= 1'b0;
					if (err_q != lzwd_pkg::ST_BYTE) begin
						res_status_q <= err_q;
					end else if (ended_q) begin
						res_status_q <= lzwd_pkg::ST_END;
					end else if (cmd == lzwd_pkg::C_RES_PULL) begin
						res_status_q <= lzwd_pkg::ST_NEED;
					end else begin
						res_status_q <= lzwd_pkg::ST_BUSY;
					end
				end
				lzwd_pkg::C_HEADER: begin
					if (hp_q == 2'd0) begin
						if (byte_q != lzwd_pkg::MAGIC_0) err_q <= lzwd_pkg::ST_BAD_MAGIC;
						else hp_q <= 2'd1;
					end else if (hp_q == 2'd1) begin
						if (byte_q != lzwd_pkg::MAGIC_1) err_q <= lzwd_pkg::ST_BAD_MAGIC;
						else hp_q <= 2'd2;
					end else begin
						bm_q  <= byte_q[7];
						smb_q <= byte_q[4:0];
						if (byte_q[4:0] > 5'(MAX_CODE_BITS)) begin
							err_q <= lzwd_pkg::ST_TOO_WIDE;
						end else begin
							nfc_q  <= byte_q[7] ? lzwd_pkg::CODE_FIRST : lzwd_pkg::CODE_CLEAR;
							cw_q   <= lzwd_pkg::START_BITS;
							wlc_q  <= lzwd_pkg::START_LIM;
							fill_q <= '0;
							cnt_q  <= '0;
							acc_q  <= '0;
							fp_q   <= 1'b1;
							ac_q   <= 1'b0;
							cp_q   <= 1'b0;
							hp_q   <= lzwd_pkg::HDR_DONE;
						end
					end
				end
				lzwd_pkg::C_GROUP_START: begin
					// a pending clear wins, else the width grows
					if (cp_q) begin
						cw_q  <= lzwd_pkg::START_BITS;
						wlc_q <= lzwd_pkg::START_LIM;
						cp_q  <= 1'b0;
					end else if (nfc_q > wlc_q) begin
						cw_q  <= cw_inc;
						wlc_q <= cw_lim;
					end
					cnt_q <= '0;
					acc_q <= '0;
				end
				lzwd_pkg::C_ADD_BYTE: begin
					fill_q <= fill_q + 5'd1;
					if (cnt_q <= 5'd16) begin
						acc_q <= acc_q | (24'(byte_q) << cnt_q);
						cnt_q <= cnt_q + 5'd8;
					end
				end
				lzwd_pkg::C_TAKE: begin
					code_q <= acc_q[15:0] & mask17[15:0];
					acc_q  <= acc_q >> cw_q;
					cnt_q  <= cnt_q - cw_q;
				end
				lzwd_pkg::C_CODE_START: begin
					if (fp_q) begin
						fp_q        <= 1'b0;
						prev_code_q <= code_q;
						prev_char_q <= code_q[7:0];
					end else if (code_q == lzwd_pkg::CODE_CLEAR[15:0] && bm_q && !ac_q) begin
						cp_q  <= 1'b1;
						ac_q  <= 1'b1;
						nfc_q <= lzwd_pkg::CODE_CLEAR;
					end else begin
						ac_q       <= 1'b0;
						incoming_q <= code_q;
						// code not yet in the table: repeat the last string
						cur_q <= ({1'b0, code_q} >= nfc_q) ? prev_code_q : code_q;
					end
				end
				lzwd_pkg::C_WALK_ADDR: begin
					if (cur_q[15:8] == 8'd0) begin
						prev_char_q <= cur_q[7:0];
					end
				end
				lzwd_pkg::C_WALK_DATA: begin
					cur_q <= pre_rd_q;
				end
				lzwd_pkg::C_CHAR_DATA: begin
					prev_char_q <= suf_rd_q;
				end
				lzwd_pkg::C_FINISH: begin
					if (tab_room) begin
						nfc_q <= nfc_q + 17'd1;
					end
					prev_code_q <= incoming_q;
				end
				lzwd_pkg::C_LAST: begin
					if (hp_q == lzwd_pkg::HDR_DONE &&
							(fill_q >= cw_q || fill_q >= 5'(lzwd_pkg::GroupMax))) begin
						fill_q <= '0;
						cnt_q  <= '0;
						acc_q  <= '0;
					end
					if (err_q == lzwd_pkg::ST_BYTE && last_q) begin
						ended_q <= 1'b1;
					end
					err_q        <= err_new;
					res_byte_q   <= '0;
					res_last_q   <= 1'b0;
					res_status_q <= (err_new != lzwd_pkg::ST_BYTE) ? err_new
						: lzwd_pkg::ST_ACCEPTED;
				end
				lzwd_pkg::C_POP_ADDR: begin
					sp_q <= sp_m1;
				end
				lzwd_pkg::C_POP_DATA: begin
					res_byte_q   <= stk_rd_q;
					res_status_q <= lzwd_pkg::ST_BYTE;
					res_last_q   <= ended_q && (sp_q == 17'd0) && (err_q == lzwd_pkg::ST_BYTE);
				end
				default: begin
					res_last_q <= res_last_q;
				end
			endcase
		end
	end

	// output register, parts the receiver from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= res_byte_q;
			out_status_q <= res_status_q;
			out_last_q   <= res_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign status    = out_status_q;
	assign out_last  = out_last_q;

	assign st.kind        = kind_q;
	assign st.err         = (err_q != lzwd_pkg::ST_BYTE);
	assign st.ended       = ended_q;
	assign st.sp_nz       = (sp_q != 17'd0);
	assign st.hdr_done    = (hp_q == lzwd_pkg::HDR_DONE);
	assign st.fill_zero   = (fill_q == 5'd0);
	assign st.code_ready  = !blocked && (cnt_q >= cw_q);
	assign st.code_simple = fp_q || (code_q == lzwd_pkg::CODE_CLEAR[15:0] && bm_q && !ac_q);
	assign st.cur_big     = (cur_q[15:8] != 8'd0);
	assign st.sp_room     = (sp_q < 17'd65535);
	assign st.out_free    = !out_valid_q || out_ready;

endmodule

// ===== src/lzw_stream_decompressor_core.sv =====
// ----------------------------------------------------------------------------
// lzw_stream_decompressor_core
// .Z (lzw) stream decoder: compressed bytes in, decoded bytes out
// ----------------------------------------------------------------------------
// each input item is either a push of one compressed byte (kind 0, header
// included, in_last on the final byte) or a pull of one decoded byte (kind 1).
// every item gives exactly one result item: a byte with status 0, or a
// status code (accepted, busy, need input, end, or a sticky error).
// items are taken one at a time; in_ready is high while the sequencer is idle.
// a data byte that opens a group first starts it; a code other than the
// first one or a clear also walks its prefix chain, one step per
// dictionary entry, where each chain step is one registered read of the
// dictionary memories followed by one stack write. the sequencer is idle
// again on the same edge that raises out_valid.
// decoded bytes wait in the reverse stack until pulled; pushes meanwhile
// return busy. reset clears all control state; no clearing pass is needed.
// the result sits in an output register, so the next item is accepted
// while the receiver stalls; only the following result then waits for it.
// ----------------------------------------------------------------------------
module lzw_stream_decompressor_core #(
	parameter int unsigned MAX_CODE_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] status,
	output logic       out_last
);

	lzwd_pkg::dp_status_t st;
	lzwd_pkg::cmd_t       cmd;
	logic                 emit;

	lzwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd),
		.emit     (emit)
	);

	lzwd_dp #(
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.kind      (kind),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.cmd       (cmd),
		.emit      (emit),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.status    (status),
		.out_last  (out_last)
	);

endmodule
